>>> hdl/xifd_pkg.sv
package xifd_pkg;

    // code byte and packed result widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RESULT_W = 149;
    localparam int unsigned TDATA_W  = 152;

    // decode phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_OP2    = 4'd1;
    localparam logic [3:0] PH_MODRM  = 4'd2;
    localparam logic [3:0] PH_SIB    = 4'd3;
    localparam logic [3:0] PH_DISP8  = 4'd4;
    localparam logic [3:0] PH_DISP32 = 4'd5;
    localparam logic [3:0] PH_IMM8   = 4'd6;
    localparam logic [3:0] PH_IMM32  = 4'd7;
    localparam logic [3:0] PH_MOFFS  = 4'd8;

    // prefix and escape bytes
    localparam logic [7:0] OP_ESCAPE   = 8'h0f;
    localparam logic [7:0] PFX_OPSIZE  = 8'h66;
    localparam logic [7:0] PFX_ADSIZE  = 8'h67;
    localparam logic [7:0] PFX_REPNZ   = 8'hf2;
    localparam logic [7:0] PFX_REPZ    = 8'hf3;
    localparam logic [7:0] PFX_SEG_ES  = 8'h26;
    localparam logic [7:0] PFX_SEG_CS  = 8'h2e;
    localparam logic [7:0] PFX_SEG_SS  = 8'h36;
    localparam logic [7:0] PFX_SEG_DS  = 8'h3e;
    localparam logic [7:0] PFX_SEG_FS  = 8'h64;
    localparam logic [7:0] PFX_SEG_GS  = 8'h65;

    // repeat modes
    localparam logic [1:0] REP_NONE  = 2'd0;
    localparam logic [1:0] REP_NZ    = 2'd1;
    localparam logic [1:0] REP_Z     = 2'd2;

    // opcode flag bits
    localparam logic [3:0] F_NONE = 4'b0000;
    localparam logic [3:0] F_M    = 4'b0001;
    localparam logic [3:0] F_I8   = 4'b0010;
    localparam logic [3:0] F_I32  = 4'b0100;
    localparam logic [3:0] F_MO   = 4'b1000;

    // present mask bits
    localparam logic [4:0] PM_MODRM = 5'b00001;
    localparam logic [4:0] PM_SIB   = 5'b00010;
    localparam logic [4:0] PM_DISP  = 5'b00100;
    localparam logic [4:0] PM_IMM   = 5'b01000;
    localparam logic [4:0] PM_MOFFS = 5'b10000;

    localparam logic [3:0] LEN_MAX = 4'd15;

    // one decoded instruction
    typedef struct packed {
        logic [3:0]         length;
        logic [4:0]         present_mask;
        logic [31:0]        memory_offset;
        logic signed [31:0] immediate;
        logic signed [31:0] displacement;
        logic [7:0]         sib_byte;
        logic [7:0]         modrm_byte;
        logic [1:0]         repeat_mode;
        logic [1:0]         size_flags;
        logic [7:0]         segment_prefix;
        logic [15:0]        opcode;
    } t_result;

    // opcode flag table: bit 8 of the index selects the 0x0F page
    function automatic logic [3:0] flag_rom(input logic [8:0] idx);
        logic [3:0] f;
        f = F_NONE;
        case (idx) inside
            [9'h000:9'h003], [9'h008:9'h00b], [9'h020:9'h023], [9'h028:9'h02b],
            [9'h030:9'h033], [9'h038:9'h03b], [9'h084:9'h08e],
            9'h0d3, 9'h0f6, 9'h0f7, 9'h0ff,
            9'h100, 9'h101, 9'h120, 9'h122, [9'h190:9'h19f],
            9'h1af, 9'h1b6, 9'h1b7, 9'h1be, 9'h1bf:
                f = F_M;
            9'h004, 9'h00c, 9'h024, 9'h02c, 9'h034, 9'h03c, 9'h06a,
            [9'h070:9'h07f], 9'h0a8, [9'h0b0:9'h0b7], 9'h0cd,
            [9'h0e4:9'h0e7], 9'h0eb:
                f = F_I8;
            9'h005, 9'h00d, 9'h025, 9'h02d, 9'h035, 9'h03d, 9'h068,
            [9'h090:9'h097], 9'h09a, 9'h0a9, [9'h0b8:9'h0bf],
            9'h0e8, 9'h0e9, 9'h0ea, [9'h180:9'h18f]:
                f = F_I32;
            9'h069, 9'h081, 9'h0c7:
                f = F_M | F_I32;
            9'h06b, 9'h080, 9'h082, 9'h083, 9'h0c0, 9'h0c1, 9'h0c6:
                f = F_M | F_I8;
            [9'h0a0:9'h0a3]:
                f = F_MO;
            default:
                f = F_NONE;
        endcase
        return f;
    endfunction

    // phase after the immediate stage (or from it, when imm_stage is set)
    function automatic logic [3:0] next_from(input logic [3:0] f, input logic imm_stage);
        logic [3:0] ph;
        ph = PH_IDLE;
        if (imm_stage && f[2]) begin
            ph = PH_IMM32;
        end else if (imm_stage && f[1]) begin
            ph = PH_IMM8;
        end else if (f[3]) begin
            ph = PH_MOFFS;
        end
        return ph;
    endfunction

endpackage

>>> hdl/xifd_core.sv
module xifd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_byte,
    input  logic                  i_take,
    output logic                  o_emit,
    output xifd_pkg::t_result     o_result
);
    import xifd_pkg::*;

    logic [3:0]  r_phase,  n_phase;
    logic [1:0]  r_cnt,    n_cnt;
    logic [15:0] r_opcode, n_opcode;
    logic [7:0]  r_seg,    n_seg;
    logic [1:0]  r_size,   n_size;
    logic [1:0]  r_rep,    n_rep;
    logic [7:0]  r_modrm,  n_modrm;
    logic [7:0]  r_sib,    n_sib;
    logic [31:0] r_disp,   n_disp;
    logic [31:0] r_imm,    n_imm;
    logic [31:0] r_moffs,  n_moffs;
    logic [4:0]  r_mask,   n_mask;
    logic [3:0]  r_len,    n_len;

    logic [3:0]  f_cur;
    logic [3:0]  f_new;
    logic [4:0]  lane;
    logic        is_prefix;
    logic        last;
    logic [1:0]  mod_f;

    assign f_cur = flag_rom({r_opcode[15:8] == OP_ESCAPE, r_opcode[7:0]});
    assign lane  = {r_cnt, 3'b000};
    assign last  = (r_cnt == 2'd3);
    assign mod_f = r_modrm[7:6];

    // next state for one code byte
    always_comb begin
        n_phase  = PH_IDLE;
        n_cnt    = r_cnt;
        n_opcode = r_opcode;
        n_seg    = r_seg;
        n_size   = r_size;
        n_rep    = r_rep;
        n_modrm  = r_modrm;
        n_sib    = r_sib;
        n_disp   = r_disp;
        n_imm    = r_imm;
        n_moffs  = r_moffs;
        n_mask   = r_mask;
        n_len    = (r_len == LEN_MAX) ? LEN_MAX : r_len + 4'd1;
        is_prefix = 1'b0;
        f_new    = F_NONE;
        unique case (r_phase)
            PH_OP2: begin
                n_opcode = {OP_ESCAPE, i_byte};
                f_new    = flag_rom({1'b1, i_byte});
                n_phase  = f_new[0] ? PH_MODRM : next_from(f_new, 1'b1);
            end
            PH_MODRM: begin
                n_modrm = i_byte;
                n_mask  = r_mask | PM_MODRM;
                if (i_byte[7:6] != 2'd3 && i_byte[2:0] == 3'd4) begin
                    n_phase = PH_SIB;
                end else if (i_byte[7:6] == 2'd2
                             || (i_byte[7:6] == 2'd0 && i_byte[2:0] == 3'd5)) begin
                    n_phase = PH_DISP32;
                end else if (i_byte[7:6] == 2'd1) begin
                    n_phase = PH_DISP8;
                end else begin
                    n_phase = next_from(f_cur, 1'b1);
                end
            end
            PH_SIB: begin
                n_sib  = i_byte;
                n_mask = r_mask | PM_SIB;
                if (mod_f == 2'd2 || (mod_f == 2'd0 && i_byte[2:0] == 3'd5)) begin
                    n_phase = PH_DISP32;
                end else if (mod_f == 2'd1) begin
                    n_phase = PH_DISP8;
                end else begin
                    n_phase = next_from(f_cur, 1'b1);
                end
            end
            PH_DISP8: begin
                n_disp  = {{24{i_byte[7]}}, i_byte};
                n_mask  = r_mask | PM_DISP;
                n_phase = next_from(f_cur, 1'b1);
            end
            PH_DISP32: begin
                n_disp[lane +: 8] = r_disp[lane +: 8] | i_byte;
                n_mask  = r_mask | PM_DISP;
                n_cnt   = r_cnt + 2'd1;
                n_phase = last ? next_from(f_cur, 1'b1) : PH_DISP32;
            end
            PH_IMM8: begin
                n_imm   = {{24{i_byte[7]}}, i_byte};
                n_mask  = r_mask | PM_IMM;
                n_phase = next_from(f_cur, 1'b0);
            end
            PH_IMM32: begin
                n_imm[lane +: 8] = r_imm[lane +: 8] | i_byte;
                n_mask  = r_mask | PM_IMM;
                n_cnt   = r_cnt + 2'd1;
                n_phase = last ? next_from(f_cur, 1'b0) : PH_IMM32;
            end
            PH_MOFFS: begin
                n_moffs[lane +: 8] = r_moffs[lane +: 8] | i_byte;
                n_mask  = r_mask | PM_MOFFS;
                n_cnt   = r_cnt + 2'd1;
                n_phase = last ? PH_IDLE : PH_MOFFS;
            end
            // idle and unused codes: prefix or first opcode byte
            default: begin
                if (i_byte == PFX_SEG_ES || i_byte == PFX_SEG_CS || i_byte == PFX_SEG_SS
                    || i_byte == PFX_SEG_DS || i_byte == PFX_SEG_FS
                    || i_byte == PFX_SEG_GS) begin
                    is_prefix = 1'b1;
                    n_seg     = i_byte;
                end else if (i_byte == PFX_OPSIZE) begin
                    is_prefix = 1'b1;
                    n_size    = r_size | 2'b01;
                end else if (i_byte == PFX_ADSIZE) begin
                    is_prefix = 1'b1;
                    n_size    = r_size | 2'b10;
                end else if (i_byte == PFX_REPNZ) begin
                    is_prefix = 1'b1;
                    n_rep     = REP_NZ;
                end else if (i_byte == PFX_REPZ) begin
                    is_prefix = 1'b1;
                    n_rep     = REP_Z;
                end else begin
                    n_opcode = {8'h00, i_byte};
                    f_new    = flag_rom({1'b0, i_byte});
                    if (i_byte == OP_ESCAPE) begin
                        n_phase = PH_OP2;
                    end else begin
                        n_phase = f_new[0] ? PH_MODRM : next_from(f_new, 1'b1);
                    end
                end
            end
        endcase
    end

    assign o_emit = !is_prefix && (n_phase == PH_IDLE);

    // finished instruction
    always_comb begin
        o_result.opcode         = n_opcode;
        o_result.segment_prefix = n_seg;
        o_result.size_flags     = n_size;
        o_result.repeat_mode    = n_rep;
        o_result.modrm_byte     = n_modrm;
        o_result.sib_byte       = n_sib;
        o_result.displacement   = n_disp;
        o_result.immediate      = n_imm;
        o_result.memory_offset  = n_moffs;
        o_result.present_mask   = n_mask;
        o_result.length         = n_len;
    end

    // gathered fields; cleared at reset and when an instruction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && o_emit)) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_opcode <= '0;
            r_seg    <= '0;
            r_size   <= '0;
            r_rep    <= REP_NONE;
            r_modrm  <= '0;
            r_sib    <= '0;
            r_disp   <= '0;
            r_imm    <= '0;
            r_moffs  <= '0;
            r_mask   <= '0;
            r_len    <= '0;
        end else if (i_take) begin
            r_phase  <= is_prefix ? PH_IDLE : n_phase;
            r_cnt    <= n_cnt;
            r_opcode <= n_opcode;
            r_seg    <= n_seg;
            r_size   <= n_size;
            r_rep    <= n_rep;
            r_modrm  <= n_modrm;
            r_sib    <= n_sib;
            r_disp   <= n_disp;
            r_imm    <= n_imm;
            r_moffs  <= n_moffs;
            r_mask   <= n_mask;
            r_len    <= n_len;
        end
    end

endmodule

>>> hdl/xifd_out_buf.sv
module xifd_out_buf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  xifd_pkg::t_result                 i_result,
    output logic                              o_free,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [xifd_pkg::TDATA_W-1:0]      o_data
);
    import xifd_pkg::*;

    logic          r_valid;
    t_result       r_result;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {{(TDATA_W - RESULT_W){1'b0}}, r_result};

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> hdl/x86_instruction_field_decoder.sv
// x86 instruction field decoder, 32-bit addressing.
// Input stream: one code byte per word on i_s_axis_tdata. Prefixes, opcode
// (one byte or 0x0F escape), ModRM, SIB, displacement, immediate and moffs32
// are gathered; the byte that completes an instruction yields one output word
// with all fields and the length (saturating at 15). Prefix and middle bytes
// yield no word.
// Throughput: one code byte per cycle while no stall holds the input. Each
// byte passes an input register, then the phase machine writes the result
// register, from which a completing byte shows on the output.
// Stall: while the output word is held, bytes that do not finish an
// instruction still flow; a byte that would finish one waits in the input
// register until the output register frees up, and input tready then drops.
// Reset (i_rst_n low, synchronous): decode returns to waiting for a prefix or
// opcode, all gathered fields clear and both registers empty.
module x86_instruction_field_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // code_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // opcode[15:0] segment_prefix[23:16] size_flags[25:24] repeat_mode[27:26]
    // modrm_byte[35:28] sib_byte[43:36] displacement[75:44] immediate[107:76]
    // memory_offset[139:108] present_mask[144:140] length[148:145] zero[151:149]
    output logic [xifd_pkg::TDATA_W-1:0]  o_m_axis_tdata
);
    import xifd_pkg::*;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          emit;
    logic          take;
    logic          out_free;
    t_result       result;

    // byte is processed unless it completes an instruction with output full
    assign take            = r_in_valid && (!emit || out_free);
    assign o_s_axis_tready = !r_in_valid || take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    xifd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (r_in_byte),
        .i_take   (take),
        .o_emit   (emit),
        .o_result (result)
    );

    xifd_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule
